// ===== src/csrf_pkg.sv =====
// Shared types and constants for the Chien search root finder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package csrf_pkg;

  // Field widths of the channel words.
  localparam int COEF_W     = 10;
  localparam int IDX_W      = 4;
  localparam int POS_W      = 10;
  localparam int CNT_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Operation codes of an input word.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_POLY  = 2'd0,
    REG_DIRECTION   = 2'd1,
    REG_USED_LENGTH = 2'd2,
    REG_DEGREE      = 2'd3
  } cfg_reg_t;

  // Register values after reset.
  localparam logic [COEF_W-1:0] FIELD_POLY_RST  = 10'd9;
  localparam logic              DIRECTION_RST   = 1'b0;
  localparam logic [POS_W-1:0]  USED_LENGTH_RST = 10'd1023;
  localparam logic [IDX_W-1:0]  DEGREE_RST      = 4'd8;

  // The root count saturates here.
  localparam logic [CNT_W-1:0] ROOT_MAX = 10'd1023;

  // Per-cell controls: write the loaded coefficient, or step by one position.
  typedef struct packed {
    logic load;
    logic step;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/csrf_cfg_if.sv =====
// Configuration write channel of the Chien search root finder.
// Depends on csrf_pkg for the index and data widths.
`default_nettype none

interface csrf_cfg_if;
  import csrf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/csrf_in_if.sv =====
// Input word channel of the Chien search root finder: loads and evaluates.
// Depends on csrf_pkg for the operation type and field widths.
`default_nettype none

interface csrf_in_if;
  import csrf_pkg::*;

  logic              valid;
  logic              ready;
  op_t               operation;
  logic [IDX_W-1:0]  coef_index;
  logic [COEF_W-1:0] coef_value;

  modport source (output valid, output operation, output coef_index, output coef_value,
                  input ready);
  modport sink   (input valid, input operation, input coef_index, input coef_value,
                  output ready);
endinterface

`default_nettype wire

// ===== src/csrf_out_if.sv =====
// Result word channel of the Chien search root finder.
// Depends on csrf_pkg for the field widths.
`default_nettype none

interface csrf_out_if;
  import csrf_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  position;
  logic              is_root;
  logic [COEF_W-1:0] locator_value;
  logic [CNT_W-1:0]  root_count;
  logic              last;

  modport source (output valid, output position, output is_root, output locator_value,
                  output root_count, output last, input ready);
  modport sink   (input valid, input position, input is_root, input locator_value,
                  input root_count, input last, output ready);
endinterface

`default_nettype wire

// ===== src/chien_search_root_finder.sv =====
// Top level of the Chien search root finder: configuration, cell chain, output register.
// Depends on csrf_pkg, the three channel interfaces and csrf_cell.
`default_nettype none

// Usage.
// The cfg_ch channel writes the four configuration registers by index: field
// polynomial, search direction, used length and locator degree. It is always ready.
// The in_ch channel carries words of two kinds. A load word writes one locator
// coefficient and clears the position and root counters; it gives no result.
// An evaluate word sums the coefficient registers for the current position,
// steps every used register by its power of alpha and advances the position.
// Each evaluate word gives exactly one result word on out_ch, in the cycle after
// it is accepted, from an output register.
// Throughput is one word per cycle. A word is accepted while the output
// register is empty or is being emptied in the same cycle, so a stalled
// receiver holds the input off only once a result is waiting.
// The step powers alpha^j come from a chain of power registers, one per cell,
// each taking its neighbor's value times alpha. After reset and after every
// configuration write the chain must settle again, and in_ch is not ready
// until the settle counter has run out.
// Reset restores the register defaults, clears the coefficients and both
// counters, and empties the output register.
module chien_search_root_finder #(
  parameter int FIELD_BITS = 10,
  parameter int MAX_DEGREE = 8
) (
  input wire logic   clk,
  input wire logic   rst_n,
  csrf_cfg_if.sink   cfg_ch,
  csrf_in_if.sink    in_ch,
  csrf_out_if.source out_ch
);
  import csrf_pkg::*;

  localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
  localparam int SETTLE_W = $clog2(MAX_DEGREE + 2);
  localparam int EXT_W    = FIELD_BITS + COEF_W;
  localparam logic [SETTLE_W-1:0]   SETTLE_LEN = SETTLE_W'(MAX_DEGREE + 1);
  localparam logic [FIELD_BITS-1:0] POS_WRAP   = FIELD_BITS'((1 << FIELD_BITS) - 2);
  localparam logic [FIELD_BITS-1:0] POW_SEED   = FIELD_BITS'(1);

  // Configuration registers.
  logic [COEF_W-1:0] field_poly_r;
  logic              direction_r;
  logic [POS_W-1:0]  used_len_r;
  logic [IDX_W-1:0]  degree_r;

  logic [SETTLE_W-1:0] settle_r;
  logic [SETTLE_W-1:0] settle_nxt;

  logic [FIELD_BITS-1:0] pos_r;
  logic [FIELD_BITS-1:0] pos_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;

  logic              out_valid_r;
  logic [POS_W-1:0]  out_pos_r;
  logic              out_root_r;
  logic [COEF_W-1:0] out_val_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_last_r;

  logic cfg_acc;
  logic in_acc;
  logic load_acc;
  logic eval_acc;
  logic out_take;

  logic [EXT_W-1:0]      fp_ext;
  logic [FIELD_BITS-1:0] fp_m;
  logic [FIELD_BITS-1:0] rcp_src;
  logic [FIELD_BITS-1:0] rcp_poly;
  logic [FIELD_BITS-1:0] step_poly;
  logic [EXT_W-1:0]      coef_ext;
  logic [FIELD_BITS-1:0] coef_in;
  logic [DEG_W-1:0]      deg_eff;

  cell_ctl_t             cell_ctl [0:MAX_DEGREE];
  logic [FIELD_BITS-1:0] coef_q   [0:MAX_DEGREE];
  logic [FIELD_BITS-1:0] pow_link [0:MAX_DEGREE];

  logic [FIELD_BITS-1:0] sum;
  logic [EXT_W-1:0]      sum_ext;
  logic [EXT_W-1:0]      pos_ext;
  logic [EXT_W-1:0]      len_ext;
  logic                  is_root;
  logic                  is_last;

  // ---------------------------------------------------------------------------
  // Handshakes.
  // ---------------------------------------------------------------------------
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign out_take     = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (settle_r == '0) && (!out_valid_r || out_ch.ready);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign load_acc     = in_acc && (in_ch.operation == OP_LOAD);
  assign eval_acc     = in_acc && (in_ch.operation == OP_EVAL);

  // ---------------------------------------------------------------------------
  // Configuration registers. Any write restarts the settling of the power chain.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_poly_r <= FIELD_POLY_RST;
      direction_r  <= DIRECTION_RST;
      used_len_r   <= USED_LENGTH_RST;
      degree_r     <= DEGREE_RST;
    end else if (cfg_acc) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_FIELD_POLY:  field_poly_r <= cfg_ch.data[COEF_W-1:0];
        REG_DIRECTION:   direction_r  <= cfg_ch.data[0];
        REG_USED_LENGTH: used_len_r   <= cfg_ch.data[POS_W-1:0];
        REG_DEGREE:      degree_r     <= cfg_ch.data[IDX_W-1:0];
        default:         field_poly_r <= field_poly_r;
      endcase
    end
  end

  always_comb begin
    settle_nxt = settle_r;
    if (cfg_acc) begin
      settle_nxt = SETTLE_LEN;
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - SETTLE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_LEN;
    end else begin
      settle_r <= settle_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Field polynomial. The forward step uses it directly; the backward step is
  // done in the bit-reversed domain under the reciprocal polynomial, whose low
  // bits are the reversal of the full polynomial shifted right by one.
  // ---------------------------------------------------------------------------
  assign fp_ext  = {{FIELD_BITS{1'b0}}, field_poly_r};
  assign fp_m    = fp_ext[FIELD_BITS-1:0];
  assign rcp_src = {1'b1, fp_m[FIELD_BITS-1:1]};

  always_comb begin
    for (int i = 0; i < FIELD_BITS; i++) begin
      rcp_poly[i] = rcp_src[FIELD_BITS-1-i];
    end
  end

  assign step_poly = direction_r ? fp_m : rcp_poly;

  assign coef_ext = {{FIELD_BITS{1'b0}}, in_ch.coef_value};
  assign coef_in  = coef_ext[FIELD_BITS-1:0];

  // Degrees above MAX_DEGREE are treated as the full chain.
  always_comb begin
    if (int'(degree_r) > MAX_DEGREE) begin
      deg_eff = DEG_W'(MAX_DEGREE);
    end else begin
      deg_eff = DEG_W'(degree_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain. Cell j holds coefficient j and the power x^j; cell zero holds
  // the seed one and never steps.
  // ---------------------------------------------------------------------------
  assign pow_link[0] = POW_SEED;

  for (genvar j = 0; j <= MAX_DEGREE; j++) begin : g_cell
    assign cell_ctl[j].load = load_acc && (int'(in_ch.coef_index) == j);
    assign cell_ctl[j].step = eval_acc && (j >= 1) && (j <= int'(deg_eff));

    if (j < MAX_DEGREE) begin : g_link
      csrf_cell #(
        .FIELD_BITS (FIELD_BITS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cell_ctl[j]),
        .backward (!direction_r),
        .poly     (step_poly),
        .coef_in  (coef_in),
        .pow_in   (pow_link[j]),
        .coef_q   (coef_q[j]),
        .nb_out   (pow_link[j+1])
      );
    end else begin : g_end
      csrf_cell #(
        .FIELD_BITS (FIELD_BITS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cell_ctl[j]),
        .backward (!direction_r),
        .poly     (step_poly),
        .coef_in  (coef_in),
        .pow_in   (pow_link[j]),
        .coef_q   (coef_q[j]),
        .nb_out   ()
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Locator value at the current position and the result fields.
  // ---------------------------------------------------------------------------
  always_comb begin
    sum = '0;
    for (int j = 0; j <= MAX_DEGREE; j++) begin
      if (j <= int'(deg_eff)) begin
        sum = sum ^ coef_q[j];
      end
    end
  end

  assign is_root = (sum == '0);
  assign sum_ext = EXT_W'(sum);
  assign pos_ext = EXT_W'(pos_r);
  assign len_ext = EXT_W'(used_len_r);
  // A zero used length never marks a last position.
  assign is_last = (used_len_r != '0) && (pos_ext == len_ext - EXT_W'(1));

  // The position wraps at the order of alpha so it tracks the stepped registers.
  always_comb begin
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    if (load_acc) begin
      pos_nxt = '0;
      cnt_nxt = '0;
    end else if (eval_acc) begin
      pos_nxt = (pos_r == POS_WRAP) ? '0 : pos_r + FIELD_BITS'(1);
      if (is_root && (cnt_r != ROOT_MAX)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eval_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_acc) begin
      out_pos_r  <= pos_ext[POS_W-1:0];
      out_root_r <= is_root;
      out_val_r  <= sum_ext[COEF_W-1:0];
      out_cnt_r  <= cnt_nxt;
      out_last_r <= is_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.position      = out_pos_r;
  assign out_ch.is_root       = out_root_r;
  assign out_ch.locator_value = out_val_r;
  assign out_ch.root_count    = out_cnt_r;
  assign out_ch.last          = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_eval_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    eval_acc |=> out_valid_r)
    else $error("evaluate word accepted without a result in the output register");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> (pos_r == '0) && (cnt_r == '0))
    else $error("load did not clear the position and root counters");

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> !in_ch.ready)
    else $error("input accepted before the power chain settled");

  a_root_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_root_r) |-> (out_val_r == '0))
    else $error("root reported with a nonzero locator value");

endmodule

`default_nettype wire

// ===== src/csrf_cell.sv =====
// One search cell: a locator coefficient register and its step power.
// Depends on csrf_pkg for the cell control struct.
`default_nettype none

module csrf_cell #(
  parameter int FIELD_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire csrf_pkg::cell_ctl_t   ctl,
  input  wire logic                  backward,
  input  wire logic [FIELD_BITS-1:0] poly,
  input  wire logic [FIELD_BITS-1:0] coef_in,
  input  wire logic [FIELD_BITS-1:0] pow_in,
  output logic      [FIELD_BITS-1:0] coef_q,
  output logic      [FIELD_BITS-1:0] nb_out
);
  import csrf_pkg::*;

  logic [FIELD_BITS-1:0] coef_r;
  logic [FIELD_BITS-1:0] coef_nxt;
  logic [FIELD_BITS-1:0] pow_r;
  logic [FIELD_BITS-1:0] step_a;
  logic [FIELD_BITS-1:0] step_m;

  // Multiply by x modulo x^FIELD_BITS + p.
  function automatic logic [FIELD_BITS-1:0] mulx(input logic [FIELD_BITS-1:0] a,
                                                 input logic [FIELD_BITS-1:0] p);
    return {a[FIELD_BITS-2:0], 1'b0} ^ (a[FIELD_BITS-1] ? p : '0);
  endfunction

  // Ring product modulo x^FIELD_BITS + p, most significant bit of b first.
  function automatic logic [FIELD_BITS-1:0] gf_mul(input logic [FIELD_BITS-1:0] a,
                                                   input logic [FIELD_BITS-1:0] b,
                                                   input logic [FIELD_BITS-1:0] p);
    logic [FIELD_BITS-1:0] acc;
    acc = '0;
    for (int i = FIELD_BITS - 1; i >= 0; i--) begin
      acc = mulx(acc, p) ^ (b[i] ? a : '0);
    end
    return acc;
  endfunction

  function automatic logic [FIELD_BITS-1:0] bit_rev(input logic [FIELD_BITS-1:0] a);
    logic [FIELD_BITS-1:0] r;
    for (int i = 0; i < FIELD_BITS; i++) begin
      r[i] = a[FIELD_BITS-1-i];
    end
    return r;
  endfunction

  // The power register follows its neighbor, so once the chain has settled cell j holds x^j.
  always_ff @(posedge clk) begin
    pow_r <= pow_in;
  end

  assign nb_out = mulx(pow_r, poly);

  // A backward step is a forward step on the bit-reversed value under the
  // reciprocal polynomial, so the same multiplier serves both directions.
  always_comb begin
    step_a = backward ? bit_rev(coef_r) : coef_r;
    step_m = gf_mul(step_a, pow_r, poly);
    coef_nxt = coef_r;
    if (ctl.load) begin
      coef_nxt = coef_in;
    end else if (ctl.step) begin
      coef_nxt = backward ? bit_rev(step_m) : step_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef_q = coef_r;

endmodule

`default_nettype wire

// ===== bench/csrf_tb_pkg.sv =====
// Scoreboard for the Chien search root finder bench: a bit-exact predictor
// of every evaluate word and the queue of results it still waits for.
// Depends on csrf_pkg for the field widths, op codes and register indexes.
package csrf_tb_pkg;
  import csrf_pkg::*;

  localparam int DEG_MAX     = 8;
  localparam int FIELD_ORDER = 1023;
  localparam int SHOWN_MAX   = 200;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic              is_root;
    logic [COEF_W-1:0] locator_value;
    logic [CNT_W-1:0]  root_count;
    logic              last;
  } eval_result_t;

  // Multiply by x modulo x^10 + poly.
  function automatic logic [COEF_W-1:0] times_x(logic [COEF_W-1:0] a, logic [COEF_W-1:0] poly);
    return a[COEF_W-1] ? ({a[COEF_W-2:0], 1'b0} ^ poly) : {a[COEF_W-2:0], 1'b0};
  endfunction

  // Divide by x: fold in the full polynomial when bit 0 is set, then shift right.
  function automatic logic [COEF_W-1:0] over_x(logic [COEF_W-1:0] a, logic [COEF_W-1:0] poly);
    logic [COEF_W:0] t;
    t = a[0] ? ({1'b0, a} ^ {1'b1, poly}) : {1'b0, a};
    return t[COEF_W:1];
  endfunction

  function automatic logic [COEF_W-1:0] gf_mul(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b,
                                               logic [COEF_W-1:0] poly);
    logic [COEF_W-1:0] acc;
    acc = '0;
    for (int i = COEF_W - 1; i >= 0; i--) begin
      acc = times_x(acc, poly);
      if (b[i]) acc ^= a;
    end
    return acc;
  endfunction

  class chien_scoreboard;
    logic [COEF_W-1:0] poly;
    logic              dir;
    logic [POS_W-1:0]  used_len;
    logic [IDX_W-1:0]  degree;
    logic [COEF_W-1:0] coef [DEG_MAX+1];
    int unsigned       pos;
    int unsigned       roots;
    int                errors;
    int                shown;
    eval_result_t      pending_evals [$];

    function new();
      poly     = FIELD_POLY_RST;
      dir      = DIRECTION_RST;
      used_len = USED_LENGTH_RST;
      degree   = DEGREE_RST;
      foreach (coef[k]) coef[k] = '0;
      pos    = 0;
      roots  = 0;
      errors = 0;
      shown  = 0;
    endfunction

    // A degree above DEG_MAX counts as the full degree.
    function int eff_degree();
      return (degree > DEG_MAX) ? DEG_MAX : int'(degree);
    endfunction

    function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
      case (r)
        REG_FIELD_POLY:  poly = d;
        REG_DIRECTION:   dir = d[0];
        REG_USED_LENGTH: used_len = d;
        REG_DEGREE:      degree = d[IDX_W-1:0];
        default:         ;
      endcase
    endfunction

    function void note_word(op_t op, logic [IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      eval_result_t      r;
      logic [COEF_W-1:0] sum;
      int                d;
      if (op == OP_LOAD) begin
        if (idx <= DEG_MAX) coef[idx] = val;
        pos   = 0;
        roots = 0;
        return;
      end
      d   = eff_degree();
      sum = '0;
      for (int j = 0; j <= d; j++) sum ^= coef[j];
      r.position      = POS_W'(pos);
      r.is_root       = (sum == '0);
      r.locator_value = sum;
      if (r.is_root && roots < ROOT_MAX) roots++;
      r.root_count = CNT_W'(roots);
      r.last       = (used_len != '0) && (pos == used_len - 1);
      pending_evals.push_back(r);
      // Cell j advances by alpha^j (forward) or alpha^-j (backward).
      for (int j = 1; j <= d; j++)
        for (int k = 0; k < j; k++)
          coef[j] = dir ? times_x(coef[j], poly) : over_x(coef[j], poly);
      pos = (pos + 1 >= FIELD_ORDER) ? 0 : pos + 1;
    endfunction

    function void report(string field, int want, int got, real now);
      errors++;
      if (shown < SHOWN_MAX) begin
        shown++;
        $display("%0.1f ns: %s expected %0d, actual %0d", now, field, want, got);
      end
    endfunction

    function void check_result(eval_result_t got, real now);
      eval_result_t want;
      if (pending_evals.size() == 0) begin
        report("unexpected word, position", -1, got.position, now);
        return;
      end
      want = pending_evals.pop_front();
      if (got.position !== want.position)
        report("position", want.position, got.position, now);
      if (got.is_root !== want.is_root)
        report("is_root", want.is_root, got.is_root, now);
      if (got.locator_value !== want.locator_value)
        report("locator_value", want.locator_value, got.locator_value, now);
      if (got.root_count !== want.root_count)
        report("root_count", want.root_count, got.root_count, now);
      if (got.last !== want.last)
        report("last", want.last, got.last, now);
    endfunction
  endclass

endpackage

// ===== bench/chien_search_root_finder_tb.sv =====
// Top-level bench for the Chien search root finder: drives loads, evaluates and
// register writes, and checks every result word against the scoreboard.
// Depends on csrf_pkg, csrf_tb_pkg, the three channel interfaces and the block.
module chien_search_root_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csrf_pkg::*;
  import csrf_tb_pkg::*;

  localparam int RANDOM_WORDS  = 250;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_EVALS    = 1026;
  localparam int SHORT_SPAN    = 40;

  logic clk = 1'b0;
  logic rst_n;

  always #6 clk = ~clk;

  csrf_cfg_if cfg_ch ();
  csrf_in_if  in_ch ();
  csrf_out_if out_ch ();

  chien_search_root_finder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  chien_scoreboard sb = new();

  // Idle switches for each side, flipped per codeword so that some stretches
  // run at full rate and others carry random gaps.
  bit          idle_in      = 1'b1;
  bit          idle_out     = 1'b1;
  // A nonzero value asks the result sink for one long hold-off of that many cycles.
  int          hold_request = 0;
  int          words_sent   = 0;
  int unsigned cycle_count  = 0;

  // Watchdog. The limit is many times the slowest legal run: every word waiting
  // out the longest sender gap and receiver stall, plus the settling pauses.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("chien_search_root_finder: mismatch");
      $finish;
    end
  end

  // Result sink. With idle_out set, each word waits a random stall before ready
  // rises, unless a long hold-off was asked for. Outputs are sampled right after
  // the edge, so the values seen are those present when the word was taken.
  initial begin : result_sink
    eval_result_t got;
    int           stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else begin
        stall = idle_out ? $urandom_range(0, 5) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      got.position      = out_ch.position;
      got.is_root       = out_ch.is_root;
      got.locator_value = out_ch.locator_value;
      got.root_count    = out_ch.root_count;
      got.last          = out_ch.last;
      sb.check_result(got, $realtime);
    end
  end

  // Offer one input word and return at the edge that takes it. Valid is left
  // high so a back-to-back word never drops it; a gap lowers it first.
  task automatic send_word(op_t op, logic [IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    int gap;
    gap = idle_in ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= val;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_word(op, idx, val);
    words_sent++;
  endtask

  // Stop offering words and let every expected result drain. A trailing load
  // gives no result, so a few more cycles pass before the block counts as idle.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (sb.pending_evals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. Valid stays high so writes can follow one another.
  task automatic cfg_write(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    sb.write_reg(r, d);
  endtask

  // Write the registers picked by mask, only once the block is idle.
  task automatic configure(logic [3:0] mask, logic [COEF_W-1:0] poly, logic dir,
                           logic [POS_W-1:0] len, logic [IDX_W-1:0] deg);
    quiesce();
    if (mask[REG_FIELD_POLY])  cfg_write(REG_FIELD_POLY, poly);
    if (mask[REG_DIRECTION])   cfg_write(REG_DIRECTION, CFG_DATA_W'(dir));
    if (mask[REG_USED_LENGTH]) cfg_write(REG_USED_LENGTH, len);
    if (mask[REG_DEGREE])      cfg_write(REG_DEGREE, CFG_DATA_W'(deg));
    cfg_ch.valid <= 1'b0;
  endtask

  // One well-formed codeword: build a locator whose roots sit at chosen
  // positions, load its coefficients in random order, then evaluate.
  // For the backward search a root at position p needs the factor
  // (1 + alpha^p x); forward needs (1 + alpha^-p x). Cells above the used
  // degree get random contents, which must stay out of the sum.
  // A noisy codeword also carries ignored-index loads and stray loads
  // in the middle of the search, which clear both counters.
  task automatic run_codeword(int n_roots, int span, int n_evals, bit noisy);
    logic [COEF_W-1:0] loc [DEG_MAX+1];
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] scale;
    int                order [DEG_MAX+1];
    int                deg_eff;
    int                p;
    int                t;
    int                noise_at;
    deg_eff = sb.eff_degree();
    foreach (loc[k]) loc[k] = '0;
    loc[0] = COEF_W'(1);
    for (int r = 0; r < n_roots; r++) begin
      p = $urandom_range(0, span - 1);
      a = COEF_W'(1);
      repeat (p) a = sb.dir ? over_x(a, sb.poly) : times_x(a, sb.poly);
      for (int k = r + 1; k >= 1; k--) loc[k] ^= gf_mul(a, loc[k-1], sb.poly);
    end
    scale = COEF_W'($urandom_range(1, FIELD_ORDER));
    for (int k = 0; k <= DEG_MAX; k++)
      loc[k] = (k > deg_eff) ? COEF_W'($urandom) : gf_mul(loc[k], scale, sb.poly);

    for (int k = 0; k <= DEG_MAX; k++) order[k] = k;
    for (int k = DEG_MAX; k > 0; k--) begin
      t          = $urandom_range(0, k);
      p          = order[k];
      order[k]   = order[t];
      order[t]   = p;
    end

    noise_at = noisy ? $urandom_range(0, DEG_MAX) : -1;
    for (int k = 0; k <= DEG_MAX; k++) begin
      if (k == noise_at)
        send_word(OP_LOAD, IDX_W'($urandom_range(DEG_MAX + 1, 15)), COEF_W'($urandom));
      send_word(OP_LOAD, IDX_W'(order[k]), loc[order[k]]);
    end
    for (int e = 0; e < n_evals; e++) begin
      if (noisy && $urandom_range(0, 49) == 0)
        send_word(OP_LOAD, IDX_W'($urandom), COEF_W'($urandom));
      // The index and value fields of an evaluate are don't-care; random
      // contents make sure the block really ignores them.
      send_word(OP_EVAL, IDX_W'($urandom), COEF_W'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [COEF_W-1:0] new_poly;
    logic [POS_W-1:0]  new_len;
    logic [IDX_W-1:0]  new_deg;
    int                first_random;
    int                phase;
    int                span;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_LOAD;
    in_ch.coef_index <= '0;
    in_ch.coef_value <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_FIELD_POLY;
    cfg_ch.data      <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Right after reset every cell is zero, so each evaluate
    // is a root and the count climbs.
    send_word(OP_EVAL, '0, '0);
    send_word(OP_EVAL, '1, '1);
    // Equal top and bottom coefficients cancel at position zero. The load
    // with an index beyond the last cell writes nothing but still clears
    // the counters.
    send_word(OP_LOAD, 4'd0, '1);
    send_word(OP_LOAD, IDX_W'(DEG_MAX), '1);
    send_word(OP_LOAD, '1, 10'h155);
    repeat (3) send_word(OP_EVAL, '0, '0);
    // Reload one cell only; the others keep their stepped contents.
    send_word(OP_LOAD, 4'd1, 10'd1);
    send_word(OP_EVAL, '0, '0);

    // Degree zero with a degenerate all-zero field polynomial, forward search
    // and a two-position codeword: the search runs on past the last position.
    configure(4'hF, '0, 1'b1, 10'd2, '0);
    send_word(OP_LOAD, 4'd0, '0);
    repeat (4) send_word(OP_EVAL, '0, '0);
    // Degree above the cell count, all-ones polynomial, zero used length so
    // last never rises.
    configure(4'hF, '1, 1'b1, '0, '1);
    send_word(OP_LOAD, 4'd2, 10'h2AA);
    repeat (3) send_word(OP_EVAL, '0, '0);

    // Random part: codewords with random content under changing settings.
    // Short used lengths keep the search cheap while still reaching the last
    // position and running past it.
    first_random = words_sent;
    phase        = 0;
    while (words_sent - first_random < RANDOM_WORDS) begin
      if (phase == 0 || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       new_poly = '0;
          1:       new_poly = '1;
          2:       new_poly = COEF_W'($urandom);
          default: new_poly = FIELD_POLY_RST;
        endcase
        case ($urandom_range(0, 9))
          0:       new_len = '0;
          1:       new_len = '1;
          2:       new_len = POS_W'($urandom);
          default: new_len = POS_W'($urandom_range(1, SHORT_SPAN));
        endcase
        new_deg = $urandom_range(0, 1) ? IDX_W'($urandom) : IDX_W'(DEG_MAX);
        configure((phase == 0) ? 4'hF : 4'($urandom), new_poly, 1'($urandom), new_len,
                  new_deg);
      end
      idle_in  = ($urandom_range(0, 3) != 0);
      idle_out = ($urandom_range(0, 3) != 0);
      span = (sb.used_len == '0 || sb.used_len > 60) ? SHORT_SPAN : int'(sb.used_len);
      // Once, the sink holds off for a long while so the output register
      // fills and the block pushes back on the sender.
      if (phase == 2) hold_request = HOLD_CYCLES;
      run_codeword($urandom_range(0, sb.eff_degree()), span, span + $urandom_range(0, 3),
                   $urandom_range(0, 4) == 0);
      phase++;
    end

    // One full-length pass with an all-zero locator: every position is a
    // root, so the count saturates, last rises at the final position and the
    // position counter wraps back to zero.
    configure(4'hF, FIELD_POLY_RST, 1'($urandom), '1, IDX_W'(DEG_MAX));
    idle_in  = ($urandom_range(0, 1) != 0);
    idle_out = ($urandom_range(0, 1) != 0);
    for (int k = 0; k <= DEG_MAX; k++) send_word(OP_LOAD, IDX_W'(k), '0);
    repeat (LONG_EVALS) send_word(OP_EVAL, IDX_W'($urandom), COEF_W'($urandom));

    quiesce();
    if (sb.errors == 0)
      $display("chien_search_root_finder: match");
    else
      $display("chien_search_root_finder: mismatch");
    $finish;
  end

endmodule
